FILE: design/resource_state_tracker_macros.svh
// Assertion macros for the resource state tracker
`ifndef RESOURCE_STATE_TRACKER_MACROS_SVH
`define RESOURCE_STATE_TRACKER_MACROS_SVH

// same-cycle implication
`define RSTK_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rstk assertion failed");

// next-cycle implication
`define RSTK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rstk assertion failed");

`endif

FILE: design/rstk_pkg.sv
// Shared constants, types and helpers for the resource state tracker
package rstk_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int KEY_W       = 64;
    localparam int STATE_W     = 32;
    localparam int KEY_IO_W    = 64;
    localparam int STATE_IO_W  = 32;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam logic CMD_FIND = 1'b0;
    localparam logic CMD_SET  = 1'b1;
    localparam logic TBL_TEX  = 1'b0;
    localparam logic TBL_BUF  = 1'b1;

    typedef logic [KEY_W-1:0]   key_t;
    typedef logic [STATE_W-1:0] state_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [IDX_W-1:0]   idx_t;

    // query token walking down a cell row
    typedef struct packed {
        logic   act;
        logic   cmd;
        key_t   key;
        state_t value;
        logic   found;
        state_t st;
    } tok_t;

    typedef struct packed {
        logic   act;
        logic   hit;
        state_t st;
        logic   full;
    } res_t;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } fsm_t;

    function automatic key_t to_key(input logic [KEY_IO_W-1:0] v);
        logic [KEY_IO_W+KEY_W-1:0] ext;
        ext = (KEY_IO_W + KEY_W)'(v);
        return ext[KEY_W-1:0];
    endfunction

    function automatic state_t to_state(input logic [STATE_IO_W-1:0] v);
        logic [STATE_IO_W+STATE_W-1:0] ext;
        ext = (STATE_IO_W + STATE_W)'(v);
        return ext[STATE_W-1:0];
    endfunction

    function automatic logic [STATE_IO_W-1:0] from_state(input state_t v);
        logic [STATE_IO_W+STATE_W-1:0] ext;
        ext = (STATE_IO_W + STATE_W)'(v);
        return ext[STATE_IO_W-1:0];
    endfunction

endpackage

FILE: design/resource_state_tracker.sv
// Top level of the resource state tracker: two key/state tables as cell rows
//
//  channel | signals                                   | role
//  in      | in_valid in_ready cmd table_sel key        | find or set request item
//          | state_value                               |
//  out     | out_valid out_ready hit state_out          | one result item per request
//          | full_error                                |
//
// A request walks the selected table's cell row, one cell a cycle; the result
// is registered at the output, one item in flight at a time.
// The next item is taken once the result is registered and the output is free.
// A set that misses appends at the row's end in the cycle the token leaves it.
// Reset empties both tables (fill counts to zero); no clearing pass.
`include "resource_state_tracker_macros.svh"

module resource_state_tracker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic        table_sel,
    input  logic [63:0] key,
    input  logic [31:0] state_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        hit,
    output logic [31:0] state_out,
    output logic        full_error
);

    rstk_pkg::fsm_t   state_reg;
    rstk_pkg::fsm_t   state_next;
    rstk_pkg::tok_t   tok_reg;
    rstk_pkg::tok_t   tok_next;
    logic             sel_reg;
    rstk_pkg::tok_t   tex_tok;
    rstk_pkg::tok_t   buf_tok;
    rstk_pkg::res_t   tex_res;
    rstk_pkg::res_t   buf_res;
    rstk_pkg::res_t   res;
    logic             accept;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             hit_reg;
    logic             full_reg;
    logic [31:0]      st_out_reg;

    always_comb
    begin
        unique case (state_reg)
            rstk_pkg::ST_IDLE: state_next = accept ? rstk_pkg::ST_SCAN : rstk_pkg::ST_IDLE;
            rstk_pkg::ST_SCAN: state_next = res.act ? rstk_pkg::ST_IDLE : rstk_pkg::ST_SCAN;
            default:           state_next = rstk_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        unique case (state_reg)
            rstk_pkg::ST_IDLE: in_ready = !out_valid_reg || out_ready;
            rstk_pkg::ST_SCAN: in_ready = 1'b0;
            default:           in_ready = 1'b0;
        endcase
    end

    assign accept = in_valid && in_ready;

    always_comb
    begin
        tok_next       = tok_reg;
        tok_next.act   = accept;
        if (accept)
        begin
            tok_next.cmd   = cmd;
            tok_next.key   = rstk_pkg::to_key(key);
            tok_next.value = rstk_pkg::to_state(state_value);
            tok_next.found = 1'b0;
            tok_next.st    = '0;
        end
    end

    always_comb
    begin
        tex_tok     = tok_reg;
        buf_tok     = tok_reg;
        tex_tok.act = tok_reg.act && (sel_reg == rstk_pkg::TBL_TEX);
        buf_tok.act = tok_reg.act && (sel_reg == rstk_pkg::TBL_BUF);
    end

    rstk_chain u_tex
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .tok_in (tex_tok),
        .res    (tex_res)
    );

    rstk_chain u_buf
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .tok_in (buf_tok),
        .res    (buf_res)
    );

    assign res = tex_res.act ? tex_res : buf_res;

    always_comb
    begin
        priority if (res.act)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rstk_pkg::ST_IDLE;
            tok_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tok_reg       <= tok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sel_reg <= table_sel;
        end
        if (res.act)
        begin
            hit_reg    <= res.hit;
            full_reg   <= res.full;
            st_out_reg <= rstk_pkg::from_state(res.st);
        end
    end

    assign out_valid  = out_valid_reg;
    assign hit        = hit_reg;
    assign state_out  = st_out_reg;
    assign full_error = full_reg;

    `RSTK_ASSERT_NOW(a_one_table, clk, rst_n, 1'b1, !(tex_res.act && buf_res.act))
    `RSTK_ASSERT_NOW(a_idle_quiet, clk, rst_n, state_reg == rstk_pkg::ST_IDLE, !res.act)
    `RSTK_ASSERT_NOW(a_hit_or_full, clk, rst_n, out_valid_reg, !(hit_reg && full_reg))
    `RSTK_ASSERT_NOW(a_state_needs_hit, clk, rst_n, out_valid_reg && (st_out_reg != '0), hit_reg)
    `RSTK_ASSERT_NEXT(a_result_slot_free, clk, rst_n, res.act, out_valid_reg && $past(!out_valid_reg || out_ready))

endmodule

FILE: design/rstk_cell.sv
// One table entry: stored key and state, compare against the passing token
module rstk_cell
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  rstk_pkg::idx_t       idx,
    input  rstk_pkg::cnt_t       fill,
    input  rstk_pkg::tok_t       tok_in,
    input  logic                 app_we,
    input  rstk_pkg::key_t       app_key,
    input  rstk_pkg::state_t     app_value,
    output rstk_pkg::tok_t       tok_out
);

    rstk_pkg::key_t   key_reg;
    rstk_pkg::state_t state_reg;
    rstk_pkg::state_t state_next;
    rstk_pkg::tok_t   tok_reg;
    rstk_pkg::tok_t   tok_next;
    logic             live;
    logic             match;

    assign live  = rstk_pkg::CNT_W'(idx) < fill;
    assign match = tok_in.act && !tok_in.found && live && (key_reg == tok_in.key);

    always_comb
    begin
        tok_next       = tok_in;
        tok_next.found = tok_in.found | match;
        if (match && (tok_in.cmd == rstk_pkg::CMD_FIND))
        begin
            tok_next.st = state_reg;
        end
    end

    always_comb
    begin
        priority if (app_we)
        begin
            state_next = app_value;
        end
        else if (match && (tok_in.cmd == rstk_pkg::CMD_SET))
        begin
            state_next = tok_in.value;
        end
        else
        begin
            state_next = state_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        state_reg <= state_next;
        if (app_we)
        begin
            key_reg <= app_key;
        end
    end

    assign tok_out = tok_reg;

endmodule

FILE: design/rstk_chain.sv
// One table: a row of entry cells, fill count and append at the row's end
module rstk_chain
(
    input  logic           clk,
    input  logic           rst_n,
    input  rstk_pkg::tok_t tok_in,
    output rstk_pkg::res_t res
);

    rstk_pkg::tok_t link [rstk_pkg::TABLE_DEPTH+1];
    rstk_pkg::tok_t tail;
    rstk_pkg::cnt_t fill_reg;
    rstk_pkg::cnt_t fill_next;
    logic           miss_set;
    logic           has_room;
    logic           app_en;

    assign link[0] = tok_in;
    assign tail    = link[rstk_pkg::TABLE_DEPTH];

    assign miss_set = tail.act && (tail.cmd == rstk_pkg::CMD_SET) && !tail.found;
    assign has_room = fill_reg < rstk_pkg::CNT_W'(rstk_pkg::TABLE_DEPTH);
    assign app_en   = miss_set && has_room;

    for (genvar i = 0; i < rstk_pkg::TABLE_DEPTH; i++)
    begin : g_cell
        rstk_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .idx       (rstk_pkg::IDX_W'(i)),
            .fill      (fill_reg),
            .tok_in    (link[i]),
            .app_we    (app_en && (fill_reg == rstk_pkg::CNT_W'(i))),
            .app_key   (tail.key),
            .app_value (tail.value),
            .tok_out   (link[i+1])
        );
    end

    assign fill_next = app_en ? fill_reg + rstk_pkg::cnt_t'(1) : fill_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    always_comb
    begin
        res.act  = tail.act;
        res.hit  = tail.found;
        res.st   = (tail.cmd == rstk_pkg::CMD_FIND && tail.found) ? tail.st : '0;
        res.full = miss_set && !has_room;
    end

endmodule

FILE: dv/tb_top.sv
// Testbench for resource_state_tracker: directed and random find/set traffic checked against a scoreboard
`timescale 1ns / 100ps

module tb_top;
    import rstk_pkg::*;

    localparam int POOL_SIZE   = 40;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int TAIL_CYCLES = TABLE_DEPTH + 8;

    typedef struct {
        logic   hit;
        state_t st;
        logic   full;
    } answer_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        cmd = CMD_FIND;
    logic        table_sel = TBL_TEX;
    key_t        key = '0;
    state_t      state_value = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        hit;
    logic [31:0] state_out;
    logic        full_error;

    key_t    tbl_keys [2][TABLE_DEPTH];
    state_t  tbl_states [2][TABLE_DEPTH];
    int      tbl_fill [2];
    key_t    key_pool [2][POOL_SIZE];
    answer_t lookup_answers [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_len = 0;
    int error_count = 0;
    int cycle_count = 0;

    resource_state_tracker dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .table_sel   (table_sel),
        .key         (key),
        .state_value (state_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .hit         (hit),
        .state_out   (state_out),
        .full_error  (full_error)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL resource_state_tracker");
            $finish;
        end
    end

    // long hold-off first, random idling otherwise
    always @(posedge clk)
    begin
        if (stall_len > 0)
        begin
            out_ready <= 1'b0;
            stall_len--;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : check_results
        answer_t exp;
        if (rst_n && out_valid && out_ready)
        begin
            if (lookup_answers.size() == 0)
            begin
                error_count++;
                $display("%0t unexpected result: expected none actual hit=%0b state=%h full=%0b",
                         $time, hit, state_out, full_error);
            end
            else
            begin
                exp = lookup_answers.pop_front();
                if (hit !== exp.hit)
                begin
                    error_count++;
                    $display("%0t hit mismatch: expected %0b actual %0b", $time, exp.hit, hit);
                end
                if (state_out !== exp.st)
                begin
                    error_count++;
                    $display("%0t state_out mismatch: expected %h actual %h",
                             $time, exp.st, state_out);
                end
                if (full_error !== exp.full)
                begin
                    error_count++;
                    $display("%0t full_error mismatch: expected %0b actual %0b",
                             $time, exp.full, full_error);
                end
            end
        end
    end

    function automatic void resolve_access(input logic c, input logic t, input key_t k,
                                           input state_t v);
        int      idx;
        answer_t ans;
        idx = -1;
        ans.hit = 1'b0;
        ans.st = '0;
        ans.full = 1'b0;
        for (int i = 0; i < tbl_fill[t]; i++)
        begin
            if (tbl_keys[t][i] == k)
            begin
                idx = i;
                break;
            end
        end
        ans.hit = (idx >= 0);
        if (c == CMD_FIND)
        begin
            if (idx >= 0)
                ans.st = tbl_states[t][idx];
        end
        else if (idx >= 0)
        begin
            tbl_states[t][idx] = v;
        end
        else if (tbl_fill[t] < TABLE_DEPTH)
        begin
            tbl_keys[t][tbl_fill[t]] = k;
            tbl_states[t][tbl_fill[t]] = v;
            tbl_fill[t]++;
        end
        else
        begin
            ans.full = 1'b1;
        end
        lookup_answers.push_back(ans);
    endfunction

    task automatic send_item(input logic c, input logic t, input key_t k, input state_t v);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid    <= 1'b1;
        cmd         <= c;
        table_sel   <= t;
        key         <= k;
        state_value <= v;
        do
            @(posedge clk);
        while (!in_ready);
        resolve_access(c, t, k, v);
    endtask

    task automatic pause_until_drained();
        in_valid <= 1'b0;
        while (lookup_answers.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic build_key_pool();
        for (int t = 0; t < 2; t++)
        begin
            for (int i = 0; i < POOL_SIZE; i++)
            begin
                // odd slots are one-bit neighbors of the even ones
                if (i % 2 == 1)
                    key_pool[t][i] = key_pool[t][i-1] ^ (key_t'(1) << $urandom_range(KEY_W-1));
                else
                    key_pool[t][i] = {$urandom, $urandom};
            end
        end
    endtask

    task automatic test_empty_finds();
        send_item(CMD_FIND, TBL_TEX, '0, '1);
        send_item(CMD_FIND, TBL_BUF, '1, 32'h5a5a_a5a5);
    endtask

    task automatic test_set_and_find();
        send_item(CMD_SET, TBL_TEX, '0, '1);
        send_item(CMD_SET, TBL_BUF, '1, 32'h1234_5678);
        send_item(CMD_SET, TBL_TEX, '1, '0);
        send_item(CMD_FIND, TBL_TEX, '0, '0);
        send_item(CMD_FIND, TBL_BUF, '1, '1);
        send_item(CMD_FIND, TBL_TEX, '1, '1);
        send_item(CMD_FIND, TBL_BUF, '0, '0);
        send_item(CMD_FIND, TBL_TEX, 64'h1, '0);
        send_item(CMD_FIND, TBL_BUF, 64'h7fff_ffff_ffff_ffff, '0);
    endtask

    task automatic test_overwrite();
        send_item(CMD_SET, TBL_TEX, '0, 32'ha5a5_5a5a);
        send_item(CMD_FIND, TBL_TEX, '0, '0);
        send_item(CMD_SET, TBL_BUF, '1, '0);
        send_item(CMD_FIND, TBL_BUF, '1, 32'hffff_0000);
    endtask

    task automatic test_random_mix(input int count);
        logic   c;
        logic   t;
        key_t   k;
        state_t v;
        int     pick;
        for (int n = 0; n < count; n++)
        begin
            c = $urandom_range(1) ? CMD_SET : CMD_FIND;
            t = $urandom_range(1) ? TBL_BUF : TBL_TEX;
            pick = $urandom_range(99);
            if (pick < 85)
                k = key_pool[t][$urandom_range(POOL_SIZE-1)];
            else if (pick < 95)
                k = key_pool[t ^ 1'b1][$urandom_range(POOL_SIZE-1)];
            else
                k = {$urandom, $urandom};
            pick = $urandom_range(99);
            if (pick < 10)
                v = '0;
            else if (pick < 20)
                v = '1;
            else
                v = $urandom;
            send_item(c, t, k, v);
        end
    endtask

    // receiver blocks while the sender keeps offering items
    task automatic test_backpressure();
        int saved_pct;
        saved_pct = send_idle_pct;
        send_idle_pct = 0;
        stall_len = 400;
        for (int n = 0; n < 6; n++)
        begin
            send_item(CMD_FIND, n[0] ? TBL_BUF : TBL_TEX,
                      key_pool[n[0]][$urandom_range(POOL_SIZE-1)], $urandom);
        end
        send_idle_pct = saved_pct;
    endtask

    initial
    begin
        tbl_fill[0] = 0;
        tbl_fill[1] = 0;
        build_key_pool();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_finds();
        test_set_and_find();
        test_overwrite();
        pause_until_drained();

        send_idle_pct = 29;
        recv_idle_pct = 63;
        test_random_mix(630);
        test_backpressure();
        pause_until_drained();

        send_idle_pct = 63;
        recv_idle_pct = 29;
        test_random_mix(630);
        test_backpressure();
        pause_until_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_mix(630);

        pause_until_drained();
        if (error_count == 0)
            $display("PASS resource_state_tracker");
        else
            $display("FAIL resource_state_tracker");
        $finish;
    end

endmodule

FILE: files.f
+incdir+design
design/rstk_pkg.sv
design/rstk_cell.sv
design/rstk_chain.sv
design/resource_state_tracker.sv
dv/tb_top.sv
